// ----- rtl/core/agc_pkg.sv -----
// shared types and constants for the square-root adaptive agc core
// no dependencies; imported by every module under rtl/core
package agc_pkg;

  // default field widths
  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int GAIN_WIDTH_DEF   = 24;

  // fixed widths of the root and divide path
  localparam int RAD_W   = 34;            // radicand, magnitude scaled up
  localparam int ROOT_W  = RAD_W / 2;     // floor sqrt of the radicand
  localparam int DIVR_W  = ROOT_W + 1;    // root plus one lsb
  localparam int DVD_W   = 28;            // target level times 4096
  localparam int REG_W   = 16;            // configuration register width
  localparam int DIGIT_W = 4;             // multiplier digit size

  localparam int GAIN_ONE = 4096;         // 1.0 in q12.12

  // register reset values
  localparam logic [REG_W-1:0] TARGET_RST = 16'd22938;
  localparam logic [REG_W-1:0] ATTACK_RST = 16'd393;
  localparam logic [REG_W-1:0] DECAY_RST  = 16'd23;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_TARGET = 2'd0,
    REG_ATTACK = 2'd1,
    REG_DECAY  = 2'd2
  } cfg_reg_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQRT,
    ST_DIV,
    ST_SEL,
    ST_BLEND,
    ST_MSTART,
    ST_MUL,
    ST_OUT
  } agc_state_t;

endpackage

// ----- rtl/core/agc_sqrt.sv -----
// bit-serial integer square root, two radicand bits and one root bit a cycle
// depends on agc_pkg for the radicand and root widths
module agc_sqrt
  import agc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [RAD_W-1:0]  radicand,
  output logic              done,
  output logic [ROOT_W-1:0] root
);

  localparam int CNT_W = $clog2(ROOT_W);

  logic [RAD_W-1:0]  rad_r, rad_nxt;
  logic [ROOT_W+1:0] rem_r, rem_nxt;
  logic [ROOT_W-1:0] root_r, root_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;

  logic [ROOT_W+3:0] cand;
  logic [ROOT_W+3:0] trial;

  always_comb begin
    cand     = {rem_r, rad_r[RAD_W-1 -: 2]};
    trial    = {2'b00, root_r, 2'b01};
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rad_nxt  = radicand;
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rad_nxt = {rad_r[RAD_W-3:0], 2'b00};
      if (cand >= trial) begin
        rem_nxt  = (ROOT_W+2)'(cand - trial);
        root_nxt = {root_r[ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = (ROOT_W+2)'(cand);
        root_nxt = {root_r[ROOT_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(ROOT_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign done = done_r;
  assign root = root_r;

endmodule

// ----- rtl/core/agc_div.sv -----
// restoring divider, one quotient bit a cycle, quotient shifted into the dividend register
// depends on agc_pkg for the dividend and divisor widths
module agc_div
  import agc_pkg::*;
#(
  parameter int QUOT_W = 19
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DVD_W-1:0]  dividend,
  input  logic [DIVR_W-1:0] divisor,
  output logic              done,
  output logic [QUOT_W-1:0] quot
);

  localparam int CNT_W = $clog2(QUOT_W);

  logic [DIVR_W-1:0] dsr_r, dsr_nxt;
  logic [DIVR_W-1:0] rem_r, rem_nxt;
  logic [QUOT_W-1:0] dvd_r, dvd_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;

  logic [DIVR_W:0]   cand;

  always_comb begin
    cand     = {rem_r, dvd_r[QUOT_W-1]};
    dsr_nxt  = dsr_r;
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      // upper dividend bits are already below the divisor
      dsr_nxt  = divisor;
      rem_nxt  = DIVR_W'(dividend[DVD_W-1:QUOT_W]);
      dvd_nxt  = dividend[QUOT_W-1:0];
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (cand >= {1'b0, dsr_r}) begin
        rem_nxt = DIVR_W'(cand - {1'b0, dsr_r});
        dvd_nxt = {dvd_r[QUOT_W-2:0], 1'b1};
      end else begin
        rem_nxt = DIVR_W'(cand);
        dvd_nxt = {dvd_r[QUOT_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(QUOT_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dsr_r <= dsr_nxt;
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
  end

  assign done = done_r;
  assign quot = dvd_r;

endmodule

// ----- rtl/core/agc_smul.sv -----
// digit-serial multiplier: signed a times unsigned b, one 4-bit digit of b a cycle
// depends on agc_pkg for the digit size
module agc_smul
  import agc_pkg::*;
#(
  parameter int AW = 17,
  parameter int BW = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic signed [AW-1:0]         a,
  input  logic        [BW-1:0]         b,
  output logic                         done,
  output logic signed [AW+((BW+DIGIT_W-1)/DIGIT_W)*DIGIT_W-1:0] prod
);

  localparam int ND    = (BW + DIGIT_W - 1) / DIGIT_W;
  localparam int PBW   = ND * DIGIT_W;
  localparam int CNT_W = $clog2(ND);

  logic signed [AW-1:0]        a_r, a_nxt;
  logic        [PBW-1:0]       b_r, b_nxt;
  logic signed [AW:0]          p_r, p_nxt;
  logic        [PBW-1:0]       lo_r, lo_nxt;
  logic        [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;

  logic signed [AW+DIGIT_W+1:0] sum;

  always_comb begin
    // running partial product, low digits retire into lo_r
    sum      = p_r + a_r * $signed({1'b0, b_r[DIGIT_W-1:0]});
    a_nxt    = a_r;
    b_nxt    = b_r;
    p_nxt    = p_r;
    lo_nxt   = lo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      a_nxt    = a;
      b_nxt    = PBW'(b);
      p_nxt    = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      b_nxt   = b_r >> DIGIT_W;
      p_nxt   = (AW+1)'(sum >>> DIGIT_W);
      lo_nxt  = {sum[DIGIT_W-1:0], lo_r[PBW-1:DIGIT_W]};
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(ND - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r  <= a_nxt;
    b_r  <= b_nxt;
    p_r  <= p_nxt;
    lo_r <= lo_nxt;
  end

  assign done = done_r;
  assign prod = $signed({p_r[AW-1:0], lo_r});

endmodule

// ----- rtl/core/sqrt_adaptive_agc.sv -----
// top level of the square-root adaptive agc: sequencer, gain state and stream ports
// depends on agc_pkg, agc_sqrt, agc_div and agc_smul
//
// usage
//   in_*  : one sample request per item; in_tdata holds sample_in (q2.x, signed),
//           in_tuser holds block_start, which puts the gain back to 1.0 first
//   out_* : one gain-controlled sample per request, q1.x, saturated to +/-1
//   cfg_* : register writes (0 target level, 1 attack rate, 2 decay rate);
//           cfg_ready is always high, other indexes are dropped; write only
//           while the core is idle
// timing
//   one item at a time; in_tready is high only while the sequencer is idle
//   an item runs the bit-serial root, the divider (one quotient bit a cycle),
//   the 4-bit digit blend multiply and the output multiply one after another
//   out_tvalid rises in the same cycle as in_tready returns
// reset and stalls
//   rst_n (synchronous, active low) clears the sequencer, empties the output
//   register, sets gain to 1.0 and the registers to their reset values
//   a stalled receiver holds out_tdata; the next item is still accepted and
//   worked on, and waits only at its final step for the output register
module sqrt_adaptive_agc
  import agc_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int GAIN_WIDTH   = GAIN_WIDTH_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  // input channel
  input  logic                                    in_tvalid,
  output logic                                    in_tready,
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]       in_tdata,   // [SW-1:0] sample_in
  input  logic                                    in_tuser,   // block_start
  // result channel
  output logic                                    out_tvalid,
  input  logic                                    out_tready,
  output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]       out_tdata,  // [SW-1:0] sample_out
  // configuration write channel
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [1:0]                              cfg_index,
  input  logic [REG_W-1:0]                        cfg_data
);

  localparam int SW      = SAMPLE_WIDTH;
  localparam int GW      = GAIN_WIDTH;
  localparam int TDW     = ((SAMPLE_WIDTH + 7) / 8) * 8;
  // the root never drops below 2^((34-SW)/2), which bounds the quotient
  localparam int QUOT_W  = DVD_W - (RAD_W - SAMPLE_WIDTH) / 2;
  localparam int QX      = (QUOT_W > GAIN_WIDTH) ? QUOT_W : GAIN_WIDTH;
  // blend multiply: signed gain difference times a 16-bit rate
  localparam int BA_W    = GAIN_WIDTH + 1;
  localparam int BP_W    = BA_W + ((REG_W + DIGIT_W - 1) / DIGIT_W) * DIGIT_W;
  // output multiply: sample times gain
  localparam int OP_W    = SAMPLE_WIDTH + ((GAIN_WIDTH + DIGIT_W - 1) / DIGIT_W) * DIGIT_W;
  localparam int QV_W    = OP_W + 1 - 11;

  localparam logic [GW-1:0]          GAIN_MAX  = {GW{1'b1}};
  localparam logic [GW-1:0]          GAIN_RST  = GW'(GAIN_ONE);
  localparam logic signed [QV_W-1:0] OUT_MAX   = QV_W'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 1);
  localparam logic signed [QV_W-1:0] OUT_MIN   = ~OUT_MAX;

  // state and registers
  agc_state_t        state_r, state_nxt;
  logic [REG_W-1:0]  target_r, attack_r, decay_r;
  logic [GW-1:0]     gain_r, gain_nxt;
  logic [GW-1:0]     des_r, des_nxt;
  logic signed [SW-1:0] s_r, s_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [SW-1:0]     out_data_r, out_data_nxt;

  // unit handshakes
  logic              sqrt_start, sqrt_done;
  logic              div_start, div_done;
  logic              bmul_start, bmul_done;
  logic              omul_start, omul_done;
  logic [ROOT_W-1:0] root;
  logic [QUOT_W-1:0] quot;
  logic signed [BP_W-1:0] bprod;
  logic signed [OP_W-1:0] oprod;

  // input magnitude and radicand
  logic signed [SW:0] s_ext;
  logic [SW:0]        s_abs;
  logic [SW:0]        mag;
  logic [RAD_W-1:0]   radicand;

  // desired gain saturation
  logic [QX-1:0]      quot_x;

  // blend arithmetic
  logic signed [BA_W-1:0]  gdiff;
  logic [REG_W-1:0]        rate;
  logic signed [BP_W:0]    bsum;
  logic [GW+1:0]           gain_blend;

  // output rounding
  logic signed [OP_W:0]    rsum;
  logic signed [QV_W-1:0]  qv;
  logic [SW-1:0]           out_sat;

  logic in_acc;
  logic out_free;

  assign in_acc   = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;

  // |s| + 1, exact for the most negative code
  always_comb begin
    s_ext    = $signed({in_tdata[SW-1], in_tdata[SW-1:0]});
    s_abs    = s_ext[SW] ? (SW+1)'(-s_ext) : (SW+1)'(s_ext);
    mag      = s_abs + (SW+1)'(1);
    radicand = {mag[SW-1:0], {(RAD_W-SW){1'b0}}};
  end

  // quotient clipped to the gain range
  always_comb begin
    quot_x  = QX'(quot);
    des_nxt = (quot_x > QX'(GAIN_MAX)) ? GAIN_MAX : GW'(quot);
  end

  // gain + ((des - gain) * rate + half) >> 16, saturated
  always_comb begin
    gdiff      = $signed({1'b0, des_r}) - $signed({1'b0, gain_r});
    rate       = (des_r < gain_r) ? attack_r : decay_r;
    bsum       = $signed({{(BP_W+1-GW-REG_W){1'b0}}, gain_r, {REG_W{1'b0}}})
                 + bprod + $signed((BP_W+1)'(32768));
    gain_blend = bsum[GW+REG_W+1:REG_W];
  end

  // round half up to q1.x and clip to +/-1
  always_comb begin
    rsum = oprod + $signed((OP_W+1)'(1024));
    qv   = rsum[OP_W:11];
    if (qv > OUT_MAX) begin
      out_sat = OUT_MAX[SW-1:0];
    end else if (qv < OUT_MIN) begin
      out_sat = OUT_MIN[SW-1:0];
    end else begin
      out_sat = qv[SW-1:0];
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    gain_nxt      = gain_r;
    s_nxt         = s_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    in_tready     = 1'b0;
    sqrt_start    = 1'b0;
    div_start     = 1'b0;
    bmul_start    = 1'b0;
    omul_start    = 1'b0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          s_nxt      = $signed(in_tdata[SW-1:0]);
          sqrt_start = 1'b1;
          if (in_tuser) begin
            gain_nxt = GAIN_RST;
          end
          state_nxt = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (sqrt_done) begin
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_SEL;
        end
      end
      ST_SEL: begin
        bmul_start = 1'b1;
        state_nxt  = ST_BLEND;
      end
      ST_BLEND: begin
        if (bmul_done) begin
          gain_nxt  = (gain_blend > (GW+2)'(GAIN_MAX)) ? GAIN_MAX : gain_blend[GW-1:0];
          state_nxt = ST_MSTART;
        end
      end
      ST_MSTART: begin
        omul_start = 1'b1;
        state_nxt  = ST_MUL;
      end
      ST_MUL: begin
        if (omul_done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        // wait here only while the previous result is still held
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = out_sat;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      gain_r      <= GAIN_RST;
      out_valid_r <= 1'b0;
      target_r    <= TARGET_RST;
      attack_r    <= ATTACK_RST;
      decay_r     <= DECAY_RST;
    end else begin
      state_r     <= state_nxt;
      gain_r      <= gain_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_TARGET: target_r <= cfg_data;
          REG_ATTACK: attack_r <= cfg_data;
          REG_DECAY:  decay_r  <= cfg_data;
          default: begin
            // unknown index, write dropped
          end
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    s_r        <= s_nxt;
    out_data_r <= out_data_nxt;
    if (state_r == ST_DIV && div_done) begin
      des_r <= des_nxt;
    end
  end

  // root of the scaled magnitude
  agc_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start && in_acc),
    .radicand (radicand),
    .done     (sqrt_done),
    .root     (root)
  );

  // target * 4096 / (root + 1)
  agc_div #(
    .QUOT_W (QUOT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({target_r, 12'd0}),
    .divisor  (DIVR_W'(root) + DIVR_W'(1)),
    .done     (div_done),
    .quot     (quot)
  );

  // gain difference times the chosen rate
  agc_smul #(
    .AW (BA_W),
    .BW (REG_W)
  ) u_bmul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (bmul_start),
    .a     (gdiff),
    .b     (rate),
    .done  (bmul_done),
    .prod  (bprod)
  );

  // sample times the updated gain
  agc_smul #(
    .AW (SW),
    .BW (GW)
  ) u_omul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (omul_start),
    .a     (s_r),
    .b     (gain_r),
    .done  (omul_done),
    .prod  (oprod)
  );

  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = TDW'(out_data_r);

endmodule
